// ----- rtl/sfr_pkg.sv -----
// Shared types and constants of the shape fill rasterizer.
// No dependencies; used by the sequencer, the top level and the testbench by scoped names.
package sfr_pkg;

  // Command codes of an input transaction
  typedef enum logic [2:0] {
    OP_RECT    = 3'd0,
    OP_DIAMOND = 3'd1,
    OP_UP      = 3'd2,
    OP_DOWN    = 3'd3,
    OP_CLEAR   = 3'd4,
    OP_READ    = 3'd5
  } op_e;

  // Configuration register indexes
  localparam logic REG_CANVAS_WIDTH  = 1'b0;
  localparam logic REG_CANVAS_HEIGHT = 1'b1;

  // Byte of an empty cell
  localparam logic [7:0] BLANK_CELL = 8'd46;

  // Width of the signed span arithmetic (anchor, offsets, clipped bounds)
  localparam int SpanW = 12;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_SPAN,
    ST_WRITE,
    ST_CLEAR,
    ST_BLANK,
    ST_READ,
    ST_RDATA,
    ST_DONE
  } state_e;

  // One command as taken from the input stream
  typedef struct packed {
    logic [7:0]        brush;
    logic [7:0]        shape_size;
    logic [7:0]        shape_width;
    logic signed [8:0] pos_y;
    logic signed [8:0] pos_x;
    logic [2:0]        cmd;
  } cmd_t;

endpackage

// ----- rtl/sfr_frame_mem.sv -----
// Single-port frame buffer memory, one byte per cell, registered read data.
// Depends on nothing; instantiated by the shape fill rasterizer top level.
module sfr_frame_mem #(
  parameter int Depth = 4096,
  parameter int AddrW = 12
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  // Write or read one cell per cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sfr_sequencer.sv -----
// Command sequencer: walks shape spans, clear and blanking sweeps and cell reads
// against the frame memory. Depends on sfr_pkg.
module sfr_sequencer #(
  parameter int MaxCols = 64,
  parameter int MaxRows = 64,
  parameter int AddrW   = 12,
  parameter int ColW    = 6,
  parameter int RowW    = 6,
  parameter int CanW    = 7,
  parameter int CanH    = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // command side
  input  logic               cmd_valid_i,
  output logic               cmd_ready_o,
  input  sfr_pkg::cmd_t      cmd_i,
  // configuration writes
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic               cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  // result side
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output logic [7:0]         res_data_o,
  // frame memory
  output logic               mem_we_o,
  output logic [AddrW-1:0]   mem_addr_o,
  output logic [7:0]         mem_wdata_o,
  input  logic [7:0]         mem_rdata_i
);

  localparam int Depth = MaxRows * MaxCols;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [ColW-1:0]  LastCol  = ColW'(MaxCols - 1);

  sfr_pkg::state_e state_q, state_d;
  sfr_pkg::cmd_t   cmd_q, cmd_d;
  logic [8:0]       k_q, k_d;
  logic             half_q, half_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [ColW-1:0]  cnt_q, cnt_d;
  logic [RowW-1:0]  rr_q, rr_d;
  logic [ColW-1:0]  cc_q, cc_d;
  logic [7:0]       res_q, res_d;
  logic [CanW-1:0]  cw_q, cw_d, bw_q, bw_d;
  logic [CanH-1:0]  ch_q, ch_d, bh_q, bh_d;

  // Saturated configuration values
  logic [CanW-1:0] cfg_w;
  logic [CanH-1:0] cfg_h;
  assign cfg_w = (int'(cfg_data_i) > MaxCols) ? CanW'(MaxCols) : CanW'(cfg_data_i);
  assign cfg_h = (int'(cfg_data_i) > MaxRows) ? CanH'(MaxRows) : CanH'(cfg_data_i);

  // Accept configuration only when no command is in flight
  assign cfg_ready_o = (state_q == sfr_pkg::ST_IDLE) || (state_q == sfr_pkg::ST_BLANK);

  // Span geometry of the current k and half
  logic signed [sfr_pkg::SpanW-1:0] x_s, y_s, w_s, s_s, k_s, cw_s, ch_s;
  logic signed [sfr_pkg::SpanW-1:0] row_v, lo_v, hi_v, lo_c, hi_c;
  logic             span_end, span_ok;
  logic [AddrW-1:0] span_addr;
  logic [ColW-1:0]  span_cnt;
  logic [8:0]       k_nxt;
  logic             half_nxt;

  assign x_s  = {{3{cmd_q.pos_x[8]}}, cmd_q.pos_x};
  assign y_s  = {{3{cmd_q.pos_y[8]}}, cmd_q.pos_y};
  assign w_s  = {4'b0, cmd_q.shape_width};
  assign s_s  = {4'b0, cmd_q.shape_size};
  assign k_s  = {3'b0, k_q};
  assign cw_s = $signed(sfr_pkg::SpanW'(cw_q));
  assign ch_s = $signed(sfr_pkg::SpanW'(ch_q));

  always_comb begin
    row_v    = y_s + k_s;
    lo_v     = x_s - k_s;
    hi_v     = x_s + k_s;
    span_end = (k_q >= {1'b0, cmd_q.shape_size});
    k_nxt    = k_q + 9'd1;
    half_nxt = 1'b0;
    case (cmd_q.cmd)
      sfr_pkg::OP_RECT: begin
        lo_v     = x_s;
        hi_v     = x_s + w_s - 12'sd1;
        span_end = (cmd_q.shape_width == 8'd0) || (k_q >= {1'b0, cmd_q.shape_size});
      end
      sfr_pkg::OP_DIAMOND: begin
        // rows y+k, then the mirror row y+2s-k
        row_v    = half_q ? (y_s + (s_s <<< 1) - k_s) : (y_s + k_s);
        span_end = (k_q > {1'b0, cmd_q.shape_size});
        k_nxt    = half_q ? (k_q + 9'd1) : k_q;
        half_nxt = ~half_q;
      end
      sfr_pkg::OP_DOWN: begin
        row_v = y_s - k_s;
      end
      default: begin
      end
    endcase
  end

  // Clip the span to the active canvas
  assign lo_c    = (lo_v < 12'sd0) ? 12'sd0 : lo_v;
  assign hi_c    = (hi_v > cw_s - 12'sd1) ? (cw_s - 12'sd1) : hi_v;
  assign span_ok = (row_v >= 12'sd0) && (row_v < ch_s) && (lo_c <= hi_c);
  assign span_addr = AddrW'(row_v[RowW-1:0]) * AddrW'(MaxCols) + AddrW'(lo_c[ColW-1:0]);
  assign span_cnt  = ColW'(hi_c - lo_c);

  // Cell read address and range check
  logic             read_in;
  logic [AddrW-1:0] read_addr;
  assign read_in = (x_s >= 12'sd0) && (x_s < cw_s) && (y_s >= 12'sd0) && (y_s < ch_s);
  assign read_addr = AddrW'(y_s[RowW-1:0]) * AddrW'(MaxCols) + AddrW'(x_s[ColW-1:0]);

  // Blanking sweep: cell lies outside the retained area
  logic outside;
  assign outside = (int'(rr_q) >= int'(bh_q)) || (int'(cc_q) >= int'(bw_q));

  // Next state and outputs
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    k_d         = k_q;
    half_d      = half_q;
    addr_d      = addr_q;
    cnt_d       = cnt_q;
    rr_d        = rr_q;
    cc_d        = cc_q;
    res_d       = res_q;
    cw_d        = cw_q;
    ch_d        = ch_q;
    bw_d        = bw_q;
    bh_d        = bh_q;
    mem_we_o    = 1'b0;
    mem_addr_o  = addr_q;
    mem_wdata_o = cmd_q.brush;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;

    case (state_q)
      sfr_pkg::ST_IDLE: begin
        cmd_ready_o = ~cfg_valid_i;
        if (cmd_valid_i && !cfg_valid_i) begin
          cmd_d  = cmd_i;
          k_d    = 9'd0;
          half_d = 1'b0;
          res_d  = 8'd0;
          case (cmd_i.cmd)
            sfr_pkg::OP_RECT, sfr_pkg::OP_DIAMOND,
            sfr_pkg::OP_UP, sfr_pkg::OP_DOWN: state_d = sfr_pkg::ST_SPAN;
            sfr_pkg::OP_CLEAR: begin
              addr_d  = '0;
              state_d = sfr_pkg::ST_CLEAR;
            end
            sfr_pkg::OP_READ: state_d = sfr_pkg::ST_READ;
            default: state_d = sfr_pkg::ST_DONE;
          endcase
        end
      end

      // Set up one span, skip it when clipped away, or finish the shape
      sfr_pkg::ST_SPAN: begin
        if (span_end) begin
          state_d = sfr_pkg::ST_DONE;
        end else if (span_ok) begin
          addr_d  = span_addr;
          cnt_d   = span_cnt;
          state_d = sfr_pkg::ST_WRITE;
        end else begin
          k_d    = k_nxt;
          half_d = half_nxt;
        end
      end

      // Write the brush along the span
      sfr_pkg::ST_WRITE: begin
        mem_we_o = 1'b1;
        if (cnt_q == '0) begin
          k_d     = k_nxt;
          half_d  = half_nxt;
          state_d = sfr_pkg::ST_SPAN;
        end else begin
          addr_d = addr_q + AddrW'(1);
          cnt_d  = cnt_q - ColW'(1);
        end
      end

      // Blank every cell
      sfr_pkg::ST_INIT, sfr_pkg::ST_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_wdata_o = sfr_pkg::BLANK_CELL;
        addr_d      = addr_q + AddrW'(1);
        if (addr_q == LastAddr) begin
          state_d = (state_q == sfr_pkg::ST_CLEAR) ? sfr_pkg::ST_DONE : sfr_pkg::ST_IDLE;
        end
      end

      // Blank cells outside the retained area
      sfr_pkg::ST_BLANK: begin
        mem_we_o    = outside;
        mem_wdata_o = sfr_pkg::BLANK_CELL;
        addr_d      = addr_q + AddrW'(1);
        if (cc_q == LastCol) begin
          cc_d = '0;
          rr_d = rr_q + RowW'(1);
        end else begin
          cc_d = cc_q + ColW'(1);
        end
        if (addr_q == LastAddr) begin
          state_d = sfr_pkg::ST_IDLE;
        end
      end

      sfr_pkg::ST_READ: begin
        mem_addr_o = read_addr;
        state_d    = sfr_pkg::ST_RDATA;
      end

      sfr_pkg::ST_RDATA: begin
        res_d   = read_in ? mem_rdata_i : sfr_pkg::BLANK_CELL;
        state_d = sfr_pkg::ST_DONE;
      end

      // Hand the result over
      sfr_pkg::ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = sfr_pkg::ST_IDLE;
        end
      end

      default: state_d = sfr_pkg::ST_IDLE;
    endcase

    // Configuration write: update the canvas and start or restart blanking.
    // A restart keeps the smaller bounds so earlier shrinks still apply.
    if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == sfr_pkg::REG_CANVAS_WIDTH) begin
        cw_d = cfg_w;
      end else begin
        ch_d = cfg_h;
      end
      if (state_q == sfr_pkg::ST_IDLE || state_q == sfr_pkg::ST_BLANK) begin
        if (state_q == sfr_pkg::ST_IDLE) begin
          bw_d = cw_q;
          bh_d = ch_q;
        end
        if (cfg_index_i == sfr_pkg::REG_CANVAS_WIDTH) begin
          bw_d = (state_q == sfr_pkg::ST_BLANK && bw_q < cfg_w) ? bw_q : cfg_w;
        end else begin
          bh_d = (state_q == sfr_pkg::ST_BLANK && bh_q < cfg_h) ? bh_q : cfg_h;
        end
        addr_d  = '0;
        rr_d    = '0;
        cc_d    = '0;
        state_d = sfr_pkg::ST_BLANK;
      end
    end
  end

  // State and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfr_pkg::ST_INIT;
      addr_q  <= '0;
      rr_q    <= '0;
      cc_q    <= '0;
      k_q     <= '0;
      half_q  <= 1'b0;
      cnt_q   <= '0;
      cw_q    <= CanW'(MaxCols);
      ch_q    <= CanH'(MaxRows);
      bw_q    <= CanW'(MaxCols);
      bh_q    <= CanH'(MaxRows);
    end else begin
      state_q <= state_d;
      addr_q  <= addr_d;
      rr_q    <= rr_d;
      cc_q    <= cc_d;
      k_q     <= k_d;
      half_q  <= half_d;
      cnt_q   <= cnt_d;
      cw_q    <= cw_d;
      ch_q    <= ch_d;
      bw_q    <= bw_d;
      bh_q    <= bh_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;
    res_q <= res_d;
  end

  assign res_data_o = res_q;

endmodule

// ----- rtl/shape_fill_rasterizer.sv -----
// Top level of the shape fill rasterizer: stream ports, output register,
// sequencer and frame memory. Depends on sfr_pkg, sfr_sequencer, sfr_frame_mem.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid / s_axis_tready  command (tdata)
//  m_axis    out        m_axis_tvalid / m_axis_tready  read_value (tdata)
//  cfg       in         cfg_valid_i / cfg_ready_o      cfg_index_i, cfg_data_i
//
// A fill runs a setup step per span (clipped spans too), a write step per cell written and
// a closing step; clear sweeps every cell, a read addresses the memory and then takes the
// data, and an unknown command goes straight to hand-over. Each then hands over its result
// and goes idle. After reset a clearing pass over every cell runs with s_axis_tready low;
// each canvas write starts a blanking pass over every cell. cfg_ready_o is high only when
// idle or blanking. The result register lets the next command enter while m_axis stalls.
module shape_fill_rasterizer #(
  parameter int MAX_COLS = 64,
  parameter int MAX_ROWS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // cmd[2:0], pos_x[11:3], pos_y[20:12], shape_width[28:21],
  // shape_size[36:29], brush[44:37], zero fill [47:45]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  // read_value[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i
);

  localparam int Depth = MAX_ROWS * MAX_COLS;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CanW  = $clog2(MAX_COLS + 1);
  localparam int CanH  = $clog2(MAX_ROWS + 1);

  sfr_pkg::cmd_t    cmd;
  logic             res_valid, res_ready;
  logic [7:0]       res_data;
  logic             mem_we;
  logic [AddrW-1:0] mem_addr;
  logic [7:0]       mem_wdata, mem_rdata;
  logic             out_valid_q;
  logic [7:0]       out_data_q;

  // Unpack the command
  assign cmd.cmd         = s_axis_tdata[2:0];
  assign cmd.pos_x       = s_axis_tdata[11:3];
  assign cmd.pos_y       = s_axis_tdata[20:12];
  assign cmd.shape_width = s_axis_tdata[28:21];
  assign cmd.shape_size  = s_axis_tdata[36:29];
  assign cmd.brush       = s_axis_tdata[44:37];

  sfr_sequencer #(
    .MaxCols (MAX_COLS),
    .MaxRows (MAX_ROWS),
    .AddrW   (AddrW),
    .ColW    (ColW),
    .RowW    (RowW),
    .CanW    (CanW),
    .CanH    (CanH)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (cmd),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_data_o  (res_data),
    .mem_we_o    (mem_we),
    .mem_addr_o  (mem_addr),
    .mem_wdata_o (mem_wdata),
    .mem_rdata_i (mem_rdata)
  );

  sfr_frame_mem #(
    .Depth (Depth),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // Output register: load when empty or being drained
  assign res_ready = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res_data;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ----- sim/tb_shape_fill_rasterizer.sv -----
// Self-checking testbench for shape_fill_rasterizer: directed table, then random phases
// over several canvas sizes, checked against hand-typed values or a behavioral frame model.
// Depends on sfr_pkg and the shape_fill_rasterizer RTL.
module tb_shape_fill_rasterizer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_COLS = 64;
  localparam int MAX_ROWS = 64;
  localparam int SETTLE_CYCLES = 16;
  localparam int PHASE_ITEMS = 14;
  localparam int NUM_PHASES = 8;
  // Worst case per command is a clipped size-255 diamond; allow that for every command
  // plus the clearing and blanking passes, several times over.
  localparam longint RUN_LIMIT_NS = 250_000_000;

  // Command codes the block ignores
  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [6:0]  cfg_data_i = '0;

  shape_fill_rasterizer #(
    .MAX_COLS(MAX_COLS),
    .MAX_ROWS(MAX_ROWS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  // One directed command, with an optional hand-typed read_value
  typedef struct {
    sfr_pkg::cmd_t c;
    bit            typed;
    logic [7:0]    want;
  } dir_row_t;

  // Frame model state
  logic [7:0] frame_model [MAX_ROWS*MAX_COLS];
  int         canvas_w;
  int         canvas_h;

  logic [7:0] read_value_q [$];
  dir_row_t   dir_q [$];
  int         fail_count = 0;
  int         burst_left = 0;
  int         anchor_x = 0;
  int         anchor_y = 0;
  int         rx_cycle = 0;

  // Clock: 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Blank every cell of the model
  function automatic void clear_frame();
    foreach (frame_model[i]) frame_model[i] = sfr_pkg::BLANK_CELL;
  endfunction

  // Write one row segment, clipped to the active canvas
  function automatic void paint_span(int row, int c0, int c1, logic [7:0] b);
    if (row < 0 || row >= canvas_h) return;
    if (c0 < 0) c0 = 0;
    if (c1 > canvas_w - 1) c1 = canvas_w - 1;
    for (int c = c0; c <= c1; c++) frame_model[row*MAX_COLS + c] = b;
  endfunction

  // Apply one command to the model and return the read_value it produces
  function automatic logic [7:0] paint_command(sfr_pkg::cmd_t c);
    int x, y, w, s;
    logic [7:0] rd;
    x = $signed(c.pos_x);
    y = $signed(c.pos_y);
    w = c.shape_width;
    s = c.shape_size;
    rd = 8'd0;
    case (c.cmd)
      sfr_pkg::OP_RECT: begin
        if (w > 0)
          for (int k = 0; k < s; k++) paint_span(y + k, x, x + w - 1, c.brush);
      end
      sfr_pkg::OP_DIAMOND: begin
        for (int k = 0; k <= s; k++) begin
          paint_span(y + k, x - k, x + k, c.brush);
          paint_span(y + 2*s - k, x - k, x + k, c.brush);
        end
      end
      sfr_pkg::OP_UP: begin
        for (int k = 0; k < s; k++) paint_span(y + k, x - k, x + k, c.brush);
      end
      sfr_pkg::OP_DOWN: begin
        for (int k = 0; k < s; k++) paint_span(y - k, x - k, x + k, c.brush);
      end
      sfr_pkg::OP_CLEAR: clear_frame();
      sfr_pkg::OP_READ: begin
        if (x >= 0 && x < canvas_w && y >= 0 && y < canvas_h)
          rd = frame_model[y*MAX_COLS + x];
        else
          rd = sfr_pkg::BLANK_CELL;
      end
      default: rd = 8'd0;
    endcase
    return rd;
  endfunction

  // Saturate a canvas register and blank every cell that left the active area
  function automatic void resize_canvas(logic idx, logic [6:0] val);
    int v;
    v = val;
    if (idx == sfr_pkg::REG_CANVAS_WIDTH)
      canvas_w = (v > MAX_COLS) ? MAX_COLS : v;
    else
      canvas_h = (v > MAX_ROWS) ? MAX_ROWS : v;
    for (int r = 0; r < MAX_ROWS; r++)
      for (int c = 0; c < MAX_COLS; c++)
        if (r >= canvas_h || c >= canvas_w) frame_model[r*MAX_COLS + c] = sfr_pkg::BLANK_CELL;
  endfunction

  // Append one row of the directed table
  function automatic void add_row(logic [2:0] op, int x, int y, int w, int s, int b,
                                  bit typed, int want);
    dir_row_t row;
    row.c.cmd = op;
    row.c.pos_x = 9'(x);
    row.c.pos_y = 9'(y);
    row.c.shape_width = 8'(w);
    row.c.shape_size = 8'(s);
    row.c.brush = 8'(b);
    row.typed = typed;
    row.want = 8'(want);
    dir_q.push_back(row);
  endfunction

  // Directed table, run on the 64 by 64 canvas left by reset
  function automatic void load_directed();
    //      op                    x     y    w    s    brush  typed want
    add_row(sfr_pkg::OP_READ,      0,    0,   0,   0,  0,     1, 46);
    add_row(sfr_pkg::OP_READ,     63,   63,   0,   0,  0,     1, 46);
    add_row(sfr_pkg::OP_READ,   -256, -256, 255, 255,  255,   1, 46);
    add_row(sfr_pkg::OP_READ,    255,  255,   0,   0,  0,     1, 46);
    add_row(sfr_pkg::OP_RECT,      0,    0,   1,   1,  8'hFF, 1, 0);
    add_row(sfr_pkg::OP_READ,      0,    0,   0,   0,  0,     1, 8'hFF);
    // zero width draws nothing
    add_row(sfr_pkg::OP_RECT,      1,    1,   0,   5,  "A",   1, 0);
    add_row(sfr_pkg::OP_READ,      1,    1,   0,   0,  0,     1, 46);
    add_row(sfr_pkg::OP_RECT,   -256, -256, 255, 255,  0,     1, 0);
    add_row(sfr_pkg::OP_RECT,    -10,   60, 255, 255,  "R",   1, 0);
    add_row(sfr_pkg::OP_READ,      0,   63,   0,   0,  0,     0, 0);
    add_row(sfr_pkg::OP_READ,     63,   60,   0,   0,  0,     0, 0);
    // size-zero diamond is a single cell
    add_row(sfr_pkg::OP_DIAMOND,   5,    5,   0,   0,  "D",   1, 0);
    add_row(sfr_pkg::OP_READ,      5,    5,   0,   0,  0,     1, "D");
    add_row(sfr_pkg::OP_READ,      5,    6,   0,   0,  0,     0, 0);
    add_row(sfr_pkg::OP_DIAMOND, 255, -256,   0, 255,  "d",   1, 0);
    add_row(sfr_pkg::OP_READ,     63,   62,   0,   0,  0,     0, 0);
    add_row(sfr_pkg::OP_UP,       32,    0,   0, 255,  "U",   1, 0);
    add_row(sfr_pkg::OP_DOWN,     10,   63,   0,   3,  "V",   1, 0);
    add_row(sfr_pkg::OP_UP,       40,   40,   0,   0,  "u",   1, 0);
    add_row(sfr_pkg::OP_READ,     10,   61,   0,   0,  0,     0, 0);
    add_row(OP_SPARE6,           -1,   -1, 255, 255,  255,   1, 0);
    add_row(OP_SPARE7,            7,    9,  12,  13,  "x",   1, 0);
    add_row(sfr_pkg::OP_CLEAR,     0,    0,   0,   0,  0,     1, 0);
    add_row(sfr_pkg::OP_READ,     32,    5,   0,   0,  0,     1, 46);
  endfunction

  // Draw a random command: mostly shapes near the canvas and reads near the last shape
  function automatic sfr_pkg::cmd_t random_command();
    sfr_pkg::cmd_t c;
    int pick;
    pick = $urandom_range(0, 99);
    c.brush = 8'($urandom_range(0, 255));
    c.shape_width = 8'($urandom_range(0, 20));
    c.shape_size = 8'($urandom_range(0, 12));
    c.pos_x = 9'(anchor_x + int'($urandom_range(0, 16)) - 8);
    c.pos_y = 9'(anchor_y + int'($urandom_range(0, 24)) - 4);
    c.cmd = sfr_pkg::OP_READ;
    if (pick < 8) begin
      // noise over the full field ranges
      c.cmd = 3'($urandom_range(0, 7));
      c.pos_x = 9'($urandom_range(0, 511));
      c.pos_y = 9'($urandom_range(0, 511));
      c.shape_width = 8'($urandom_range(0, 255));
      c.shape_size = 8'($urandom_range(0, 255));
    end else if (pick < 12) begin
      c.cmd = sfr_pkg::OP_CLEAR;
    end else if (pick < 15) begin
      c.cmd = ($urandom_range(0, 1) != 0) ? OP_SPARE7 : OP_SPARE6;
    end else if (pick < 50) begin
      c.cmd = 3'($urandom_range(0, 3));
      anchor_x = int'($urandom_range(0, canvas_w + 8)) - 4;
      anchor_y = int'($urandom_range(0, canvas_h + 8)) - 4;
      c.pos_x = 9'(anchor_x);
      c.pos_y = 9'(anchor_y);
    end
    return c;
  endfunction

  // Send one command in bursts with random gaps; predict it once accepted
  task automatic push_cmd(input sfr_pkg::cmd_t c, input bit typed, input logic [7:0] want);
    int gap;
    logic [7:0] rd;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {3'b000, c};
    do @(posedge clk_i); while (!s_axis_tready);
    rd = paint_command(c);
    read_value_q.push_back(typed ? want : rd);
  endtask

  // Write one canvas register and mirror it in the model
  task automatic write_canvas(input logic idx, input int val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 7'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
    resize_canvas(idx, 7'(val));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid and wait until every pending result has arrived, then let the block go idle
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (read_value_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Receiver stall pattern: always ready, one in four, coin flip, mostly ready
  always @(negedge clk_i) begin
    rx_cycle <= rx_cycle + 1;
    case ((rx_cycle / 300) % 4)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= (rx_cycle % 4 == 0);
      2: m_axis_tready <= ($urandom_range(0, 1) != 0);
      default: m_axis_tready <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin : check_results
    logic [7:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (read_value_q.size() == 0) begin
        fail_count++;
        $display("%0t: result with no command pending, expected none actual 8'h%02h",
                 $time, m_axis_tdata);
      end else begin
        want = read_value_q.pop_front();
        if (m_axis_tdata !== want) begin
          fail_count++;
          $display("%0t: read_value mismatch, expected 8'h%02h actual 8'h%02h",
                   $time, want, m_axis_tdata);
        end
      end
    end
  end

  // Canvas settings per phase; a negative entry means a random value
  int phase_w [NUM_PHASES] = '{64, 1, 0, 127, 20, 64, -1, 5};
  int phase_h [NUM_PHASES] = '{64, 1, 9, 100, 33, 0, -1, 64};

  initial begin : stimulus
    int wv, hv;
    clear_frame();
    canvas_w = MAX_COLS;
    canvas_h = MAX_ROWS;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table
    load_directed();
    foreach (dir_q[i]) push_cmd(dir_q[i].c, dir_q[i].typed, dir_q[i].want);

    // Random phases, each on its own canvas setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      wv = (phase_w[p] < 0) ? int'($urandom_range(0, 127)) : phase_w[p];
      hv = (phase_h[p] < 0) ? int'($urandom_range(0, 127)) : phase_h[p];
      write_canvas(sfr_pkg::REG_CANVAS_WIDTH, wv);
      write_canvas(sfr_pkg::REG_CANVAS_HEIGHT, hv);
      for (int n = 0; n < PHASE_ITEMS; n++) push_cmd(random_command(), 1'b0, 8'd0);
    end
    settle();

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Timeout
  initial begin
    #(RUN_LIMIT_NS);
    $display("Verification failed");
    $finish;
  end

endmodule
